[rtl/energy_zcr_template_matcher_assert.svh]
// Assertion macros for the energy / zero-crossing template matcher
`ifndef ENERGY_ZCR_TEMPLATE_MATCHER_ASSERT_SVH
`define ENERGY_ZCR_TEMPLATE_MATCHER_ASSERT_SVH

// property that holds every clock outside reset
`define EZT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// implication whose consequent is checked on the next clock
`define EZT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ezt_pkg.sv]
// ----------------------------------------------------------------------------
// ezt_pkg
// Types and constants shared by the template matcher controller and datapath.
// ----------------------------------------------------------------------------
package ezt_pkg;

    localparam int unsigned ENERGY_W  = 45;
    localparam int unsigned CROSS_W   = 15;
    localparam int unsigned FEAT_W    = 16;
    localparam int unsigned DIST_W    = 35;
    localparam int unsigned TPL_SLOTS = 6;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned IDX_W     = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 3'd6;

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};
    localparam logic [CROSS_W-1:0]  CROSS_MAX  = {CROSS_W{1'b1}};

    localparam logic [63:0] TPL_RESET [TPL_SLOTS] = '{
        64'd57704019526680832, 64'd21674453691793536, 64'd43348464985178624,
        64'd50385232027058637, 64'd64741224660271411, 64'd57704238571716890
    };
    localparam logic [15:0] MAX_DIST_RESET = 16'd256;

    // controller -> datapath
    typedef struct packed {
        logic accum;     // take a sample into the accumulators
        logic start;     // latch accumulators, begin feature work
        logic div_step;  // one division, reciprocal-multiply or sqrt step
        logic div_next;  // never set by the controller, not read by the datapath
        logic dist_step; // compute distance to one template
        logic clear;     // clear accumulators
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic feat_done;
        logic dist_done;
    } t_status;

endpackage

[rtl/ezt_ctrl.sv]
// ----------------------------------------------------------------------------
// ezt_ctrl
// Sequencer: accumulates samples, then runs the per-record feature and
// template-search tail and hands the result word to the output register.
// ----------------------------------------------------------------------------
`include "energy_zcr_template_matcher_assert.svh"
module ezt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    output logic             o_in_ready,
    input  logic             i_out_free,
    output logic             o_out_load,
    output ezt_pkg::t_cmd    o_cmd,
    input  ezt_pkg::t_status i_status
);
    import ezt_pkg::*;

    typedef enum logic [3:0] {
        S_ACC  = 4'b0001,
        S_FEAT = 4'b0010,
        S_DIST = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   w_take;

    assign o_in_ready = (r_state == S_ACC);
    assign w_take     = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_out_load = 1'b0;
        unique case (r_state)
            S_ACC: begin
                o_cmd.accum = w_take;
                if (w_take && i_in_last) begin
                    o_cmd.start = 1'b1;
                    n_state = S_FEAT;
                end
            end
            S_FEAT: begin
                o_cmd.div_step = 1'b1;
                if (i_status.feat_done) begin
                    n_state = S_DIST;
                end
            end
            S_DIST: begin
                o_cmd.dist_step = 1'b1;
                if (i_status.dist_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_out_load  = 1'b1;
                    o_cmd.clear = 1'b1;
                    n_state = S_ACC;
                end
            end
            default: n_state = S_ACC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    `EZT_ASSERT(a_onehot, $onehot(r_state), "state not one-hot")
    `EZT_ASSERT_NEXT(a_last_leaves, w_take && i_in_last, r_state == S_FEAT,
        "last word did not start the tail")
    `EZT_ASSERT(a_no_take_busy, !(r_state != S_ACC && o_cmd.accum),
        "sample taken while busy")

endmodule

[rtl/ezt_dp.sv]
// ----------------------------------------------------------------------------
// ezt_dp
// Accumulators, a shared bit-serial divider / square-root unit, a reciprocal
// multiply for the constant divisor and a one-template-per-cycle search.
// ----------------------------------------------------------------------------
`include "energy_zcr_template_matcher_assert.svh"
module ezt_dp #(
    parameter int unsigned CNT_W    = 15,
    parameter int unsigned MAX_SAMP = 16384,
    parameter int unsigned NUM_CMD  = 6
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic signed [15:0]             i_sample,
    input  ezt_pkg::t_cmd                  i_cmd,
    output ezt_pkg::t_status               o_status,
    input  logic                           i_cfg_we,
    input  logic [ezt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [63:0]                    i_cfg_data,
    output logic                           o_recognized,
    output logic [ezt_pkg::IDX_W-1:0]      o_cmd_idx
);
    import ezt_pkg::*;

    localparam int unsigned OP_W = ENERGY_W + 8; // room for crossings * 256
    // ceil(2^39 / 1000): exact floor division for dividends below 2^29
    localparam logic [29:0] F2_RECIP = 30'd549755814;

    // configuration
    logic [63:0] r_tpl [TPL_SLOTS];
    logic [15:0] r_max_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TPL_SLOTS; i++) r_tpl[i] <= TPL_RESET[i];
            r_max_dist <= MAX_DIST_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_MAX_DIST) r_max_dist <= i_cfg_data[15:0];
            else if (i_cfg_idx < CFG_IDX_W'(TPL_SLOTS)) r_tpl[i_cfg_idx] <= i_cfg_data;
        end
    end

    // accumulators
    logic [ENERGY_W-1:0]   r_energy;
    logic [CROSS_W-1:0]    r_cross;
    logic [CNT_W-1:0]      r_count;
    logic signed [15:0]    r_prev;
    logic [31:0]           w_sq;
    logic [ENERGY_W:0]     w_esum;
    logic                  w_cross;

    assign w_sq   = 32'($signed(i_sample) * $signed(i_sample));
    assign w_esum = {1'b0, r_energy} + (ENERGY_W+1)'(w_sq);
    assign w_cross = (r_prev < 0 && i_sample > 0) || (r_prev > 0 && i_sample < 0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_energy <= '0;
            r_cross  <= '0;
            r_count  <= '0;
            r_prev   <= '0;
        end else if (i_cmd.accum) begin
            r_energy <= w_esum[ENERGY_W] ? ENERGY_MAX : w_esum[ENERGY_W-1:0];
            if (w_cross && r_cross != CROSS_MAX) r_cross <= r_cross + 1'b1;
            if (r_count != CNT_W'(MAX_SAMP)) r_count <= r_count + 1'b1;
            r_prev <= i_sample;
        end
    end

    // serial unit: ops 0 and 1 restoring division, op 2 a reciprocal multiply,
    // op 3 square root.
    // quotient bits produced MSB first, one per cycle.
    logic [1:0]         r_op;
    logic [5:0]         r_bit;
    logic [OP_W-1:0]    r_num;   // dividend shifting out / sqrt radicand
    logic [OP_W:0]      r_rem;
    logic [OP_W-1:0]    w_den_cur;
    logic [OP_W-1:0]    r_quo;
    logic [FEAT_W-1:0]  r_feat [4];
    logic               r_feat_done;

    logic [OP_W:0]      w_trial_d;
    logic [OP_W+1:0]    w_trial_s;
    logic [OP_W:0]      w_rem_sh;
    logic [OP_W+1:0]    w_rem_s2;
    logic [FEAT_W-1:0]  w_sat;
    logic [5:0]         w_nbits;
    logic [ENERGY_W-17:0] w_e_hi;
    logic [58:0]        w_f2_prod;
    logic [19:0]        w_f2_q;
    logic [FEAT_W-1:0]  w_f2;

    assign w_rem_sh  = {r_rem[OP_W-1:0], r_num[OP_W-1]};
    assign w_trial_d = w_rem_sh - {1'b0, w_den_cur};
    // sqrt: rem = rem*4 + next two bits, trial = 4q+1
    assign w_rem_s2  = {r_rem[OP_W-1:0], r_num[OP_W-1:OP_W-2]};
    assign w_trial_s = w_rem_s2 - {r_quo, 2'b01};
    assign w_nbits   = (r_op == 2'd3) ? 6'(OP_W/2) : 6'(OP_W);

    // energy / (1000 * 65536) = (energy >> 16) / 1000
    assign w_e_hi    = r_energy[ENERGY_W-1:16];
    assign w_f2_prod = w_e_hi * F2_RECIP;
    assign w_f2_q    = w_f2_prod[58:39];
    assign w_f2      = (w_f2_q > 20'd65407) ? 16'hFFFF : FEAT_W'(w_f2_q + 20'd128);

    always_comb begin
        unique case (r_op)
            2'd3: w_sat = (r_quo[OP_W-1:4] > OP_W'(16'hFFFF)) ? 16'hFFFF
                                                           : r_quo[FEAT_W+3:4];
            default: w_sat = (r_quo > OP_W'(16'hFFFF)) ? 16'hFFFF : r_quo[FEAT_W-1:0];
        endcase
    end

    // radicand sits one bit up so the bit pairs line up with the odd width
    function automatic logic [OP_W-1:0] f_num(input logic [1:0] op,
                                               input logic [ENERGY_W-1:0] e,
                                               input logic [CROSS_W-1:0] c);
        f_num = (op == 2'd1) ? OP_W'({c, 8'h00}) : OP_W'(e) << (op == 2'd3 ? 1 : 0);
    endfunction

    function automatic logic [OP_W-1:0] f_den(input logic [1:0] op,
                                               input logic [CNT_W-1:0] n);
        unique case (op)
            2'd0: f_den = OP_W'({n, 16'h0000});
            2'd1: f_den = OP_W'(n);
            default: f_den = '0;
        endcase
    endfunction

    assign w_den_cur = f_den(r_op, r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= '0;
            r_bit <= '0;
            r_feat_done <= 1'b0;
        end else if (i_cmd.start) begin
            r_op  <= '0;
            r_bit <= '0;
            r_num <= f_num(2'd0, w_esum[ENERGY_W] ? ENERGY_MAX : w_esum[ENERGY_W-1:0],
                           r_cross);
            r_rem <= '0;
            r_quo <= '0;
            r_feat_done <= 1'b0;
        end else if (i_cmd.div_step && !r_feat_done) begin
            if (r_op == 2'd2) begin
                r_feat[2] <= w_f2;
                r_bit <= '0;
                r_rem <= '0;
                r_quo <= '0;
                r_num <= f_num(2'd3, r_energy, r_cross);
                r_op  <= 2'd3;
            end else if (r_bit == w_nbits) begin
                r_feat[r_op] <= w_sat;
                r_bit <= '0;
                r_rem <= '0;
                r_quo <= '0;
                r_num <= f_num(r_op + 2'd1, r_energy, r_cross);
                r_op  <= r_op + 2'd1;
                if (r_op == 2'd3) r_feat_done <= 1'b1;
            end else begin
                r_bit <= r_bit + 1'b1;
                if (r_op == 2'd3) begin
                    r_num <= {r_num[OP_W-3:0], 2'b00};
                    if (!w_trial_s[OP_W+1]) begin
                        r_rem <= w_trial_s[OP_W:0];
                        r_quo <= {r_quo[OP_W-2:0], 1'b1};
                    end else begin
                        r_rem <= w_rem_s2[OP_W:0];
                        r_quo <= {r_quo[OP_W-2:0], 1'b0};
                    end
                end else begin
                    r_num <= {r_num[OP_W-2:0], 1'b0};
                    if (!w_trial_d[OP_W]) begin
                        r_rem <= w_trial_d;
                        r_quo <= {r_quo[OP_W-2:0], 1'b1};
                    end else begin
                        r_rem <= w_rem_sh;
                        r_quo <= {r_quo[OP_W-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // template search, one template per cycle
    logic [IDX_W-1:0]   r_ti;
    logic [DIST_W-1:0]  r_best;
    logic [IDX_W-1:0]   r_best_i;
    logic               r_dist_done;
    logic [DIST_W-1:0]  w_d2;
    logic [FEAT_W-1:0]  w_t   [4];
    logic [FEAT_W-1:0]  w_dif [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_t[k]   = r_tpl[r_ti][16*k +: 16];
            w_dif[k] = (r_feat[k] >= w_t[k]) ? r_feat[k] - w_t[k] : w_t[k] - r_feat[k];
        end
        w_d2 = DIST_W'(w_dif[0] * w_dif[0]) + DIST_W'(w_dif[1] * w_dif[1])
             + DIST_W'(w_dif[2] * w_dif[2]) + DIST_W'(w_dif[3] * w_dif[3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.start) begin
            r_ti <= '0;
            r_dist_done <= 1'b0;
        end else if (i_cmd.dist_step && !r_dist_done) begin
            if (r_ti == '0 || w_d2 < r_best) begin
                r_best   <= w_d2;
                r_best_i <= r_ti;
            end
            if (r_ti == IDX_W'(NUM_CMD - 1)) r_dist_done <= 1'b1;
            else r_ti <= r_ti + 1'b1;
        end
    end

    assign o_status.feat_done = r_feat_done;
    assign o_status.dist_done = r_dist_done;
    assign o_recognized = r_best < DIST_W'(r_max_dist * r_max_dist);
    assign o_cmd_idx    = r_best_i;

    `EZT_ASSERT(a_best_range, !r_dist_done || r_best_i < IDX_W'(NUM_CMD),
        "best index out of range")
    `EZT_ASSERT(a_count_cap, r_count <= CNT_W'(MAX_SAMP), "sample count over cap")
    `EZT_ASSERT_NEXT(a_start_clears, i_cmd.start, !r_feat_done && !r_dist_done,
        "tail flags not cleared at start")

endmodule

[rtl/energy_zcr_template_matcher.sv]
// Takes one audio word per cycle while accumulating; on the word marked last
// the input stalls for the record tail. Two divisions run in a shared
// bit-serial divider (53 steps plus one to store, each), the division by the
// constant 1000 is done as a reciprocal multiply and the square root takes
// 26 steps plus one to store. The template search then handles one template
// per cycle, and the result is loaded into the output register, so the input
// is held off for the whole record tail, longer while the previous result
// word has not been taken. The result word then sits in an output register
// while the next record's samples are taken.
// ----------------------------------------------------------------------------
// energy_zcr_template_matcher
// Energy / zero-crossing nearest-template command classifier, top level.
// ----------------------------------------------------------------------------
module energy_zcr_template_matcher #(
    parameter int unsigned MAX_SAMPLES  = 16384,
    parameter int unsigned NUM_COMMANDS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] audio_sample
    input  logic        s_axis_tlast,   // end_of_record
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] recognized, [3:1] command_index
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);
    import ezt_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);

    t_cmd       w_cmd;
    t_status    w_status;
    logic       w_load, w_rec;
    logic [IDX_W-1:0] w_idx;
    logic       r_ovalid;
    logic [3:0] r_odata;

    ezt_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_out_free (!r_ovalid || m_axis_tready),
        .o_out_load (w_load),
        .o_cmd      (w_cmd),
        .i_status   (w_status)
    );

    ezt_dp #(.CNT_W(CNT_W), .MAX_SAMP(MAX_SAMPLES), .NUM_CMD(NUM_COMMANDS)) u_dp (
        .i_clk, .i_rst_n,
        .i_sample     (s_axis_tdata),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_recognized (w_rec),
        .o_cmd_idx    (w_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) r_odata <= {w_idx, w_rec};
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'b0000, r_odata};

endmodule
